// ===== sv/gfsr_pkg.sv =====
// Shared types and constants for the twisted GFSR 64-bit random generator.
// Used by the front end, the command queue, the back end and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gfsr_pkg;

  // Table geometry.
  localparam int unsigned STATE_WORDS = 312;
  localparam int unsigned ADDR_W      = 9;
  localparam int unsigned TWIST_NEAR  = 31;
  localparam int unsigned TWIST_FAR   = 156;

  // Read index value that marks a table that was never filled.
  localparam logic [ADDR_W-1:0] UNSEEDED  = ADDR_W'(313);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);

  // Depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Seeding, twist and tempering constants.
  localparam logic [16:0] SEED_MULT   = 17'd69069;
  localparam logic [63:0] TWIST_CONST = 64'hB5026F5AA96619E9;
  localparam logic [63:0] TEMPER_B    = 64'hD66B5EF5B4DA0000;
  localparam logic [63:0] TEMPER_C    = 64'hFDED6BE000000000;
  localparam int unsigned TEMPER_S1   = 29;
  localparam int unsigned TEMPER_S2   = 17;
  localparam int unsigned TEMPER_S3   = 37;
  localparam int unsigned TEMPER_S4   = 41;

  // What the back end has to do for one item.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_FILL  = 2'd1,
    OP_TWIST = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic table_busy;
  } bk_status_t;

endpackage

`default_nettype wire

// ===== sv/gfsr_front.sv =====
// Front end of the random generator: accepts items, tracks the read index and
// turns each request into a read, fill-then-read or twist-then-read command.
// Depends on gfsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfsr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          request_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output gfsr_pkg::cmd_t     q_cmd_o
);
  import gfsr_pkg::*;

  logic [ADDR_W-1:0] idx_q, idx_d;

  assign in_ready_o = !q_full_i;
  // Items with the request bit clear are taken and dropped.
  assign q_push_o   = in_valid_i && in_ready_o && request_i;

  always_comb begin
    if (idx_q >= ADDR_W'(STATE_WORDS)) begin
      q_cmd_o.op   = (idx_q == ADDR_W'(STATE_WORDS)) ? OP_TWIST : OP_FILL;
      q_cmd_o.addr = '0;
      idx_d        = ADDR_W'(1);
    end else begin
      q_cmd_o.op   = OP_READ;
      q_cmd_o.addr = idx_q;
      idx_d        = idx_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= UNSEEDED;
    end else if (q_push_o) begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gfsr_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on gfsr_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module gfsr_queue #(
  parameter int unsigned Depth = gfsr_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire gfsr_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output gfsr_pkg::cmd_t      cmd_o
);
  import gfsr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gfsr_back.sv =====
// Back end of the random generator: owns the 312-word state table, runs the
// fill and twist sequences, reads and tempers one word per command.
// Depends on gfsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gfsr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [63:0]    seed_i,
  input  wire logic           cmd_valid_i,
  input  wire gfsr_pkg::cmd_t cmd_i,
  output logic                cmd_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [63:0]         random_value_o,
  output gfsr_pkg::bk_status_t status_o
);
  import gfsr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_MUL,
    ST_FILL_ADD,
    ST_TW_RD_I,
    ST_TW_RD_N,
    ST_TW_RD_F,
    ST_TW_WR,
    ST_RD,
    ST_TEMPER
  } state_e;

  localparam logic [ADDR_W-1:0] NearStart = ADDR_W'(TWIST_NEAR);
  localparam logic [ADDR_W-1:0] FarStart  = ADDR_W'(TWIST_FAR);

  function automatic logic [63:0] temper(input logic [63:0] x);
    logic [63:0] y;
    y = x;
    y = y ^ (y >> TEMPER_S1);
    y = y ^ ((y << TEMPER_S2) & TEMPER_B);
    y = y ^ ((y << TEMPER_S3) & TEMPER_C);
    y = y ^ (y >> TEMPER_S4);
    return y;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + ADDR_W'(1);
  endfunction

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] i_q, i_d, near_q, near_d, far_q, far_d, addr_q, addr_d;
  logic [63:0]       fill_q, fill_d;
  logic [48:0]       pl_q, pl_d;
  logic [31:0]       ph_q, ph_d;
  logic              top_q, top_d;
  logic [62:0]       low_q, low_d;
  logic              w0_lsb_q, w0_lsb_d;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       out_q, out_d;

  logic [63:0]       mem_q [STATE_WORDS];
  logic [63:0]       mem_rdata_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [63:0]       mem_wdata;

  logic [48:0]       hi_full;
  logic [63:0]       fill_word, tw_word;
  logic              out_free;

  assign hi_full   = 49'(fill_q[63:32]) * 49'(SEED_MULT);
  assign fill_word = {ph_q, 32'b0} + {15'b0, pl_q} + 64'd1;
  // Twist: (y >> 1) where y is the top bit of word i and low bits of word i+31.
  assign tw_word   = mem_rdata_q ^ {1'b0, top_q, low_q[62:1]}
                   ^ (w0_lsb_q ? 64'd0 : TWIST_CONST);
  assign out_free  = !out_valid_q || out_ready_i;

  assign cmd_ready_o         = (state_q == ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign random_value_o      = out_q;
  assign status_o.idle       = (state_q == ST_IDLE);
  assign status_o.table_busy = (state_q == ST_FILL_MUL) || (state_q == ST_FILL_ADD) ||
                               (state_q == ST_TW_RD_I) || (state_q == ST_TW_RD_N) ||
                               (state_q == ST_TW_RD_F) || (state_q == ST_TW_WR);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    near_d      = near_q;
    far_d       = far_q;
    addr_d      = addr_q;
    fill_d      = fill_q;
    pl_d        = pl_q;
    ph_d        = ph_q;
    top_d       = top_q;
    low_d       = low_q;
    w0_lsb_d    = w0_lsb_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_addr    = addr_q;
    mem_we      = 1'b0;
    mem_wdata   = fill_word;

    case (state_q)
      ST_IDLE: begin
        mem_addr = cmd_i.addr;
        if (cmd_valid_i) begin
          addr_d = cmd_i.addr;
          case (cmd_i.op)
            OP_FILL: begin
              mem_we    = 1'b1;
              mem_wdata = seed_i;
              fill_d    = seed_i;
              w0_lsb_d  = seed_i[0];
              i_d       = ADDR_W'(1);
              state_d   = ST_FILL_MUL;
            end
            OP_TWIST: begin
              i_d     = '0;
              near_d  = NearStart;
              far_d   = FarStart;
              state_d = ST_TW_RD_I;
            end
            default: begin
              state_d = ST_TEMPER;
            end
          endcase
        end
      end
      ST_FILL_MUL: begin
        pl_d    = 49'(fill_q[31:0]) * 49'(SEED_MULT);
        ph_d    = hi_full[31:0];
        state_d = ST_FILL_ADD;
      end
      ST_FILL_ADD: begin
        mem_addr  = i_q;
        mem_we    = 1'b1;
        mem_wdata = fill_word;
        fill_d    = fill_word;
        i_d       = i_q + ADDR_W'(1);
        state_d   = (i_q == LAST_ADDR) ? ST_RD : ST_FILL_MUL;
      end
      ST_TW_RD_I: begin
        mem_addr = i_q;
        state_d  = ST_TW_RD_N;
      end
      ST_TW_RD_N: begin
        mem_addr = near_q;
        top_d    = mem_rdata_q[63];
        state_d  = ST_TW_RD_F;
      end
      ST_TW_RD_F: begin
        mem_addr = far_q;
        low_d    = mem_rdata_q[62:0];
        state_d  = ST_TW_WR;
      end
      ST_TW_WR: begin
        mem_addr  = i_q;
        mem_we    = 1'b1;
        mem_wdata = tw_word;
        // Later words test the low bit of the already twisted word 0.
        if (i_q == '0) begin
          w0_lsb_d = tw_word[0];
        end
        i_d     = wrap_inc(i_q);
        near_d  = wrap_inc(near_q);
        far_d   = wrap_inc(far_q);
        state_d = (i_q == LAST_ADDR) ? ST_RD : ST_TW_RD_I;
      end
      ST_RD: begin
        state_d = ST_TEMPER;
      end
      ST_TEMPER: begin
        // The read address is held, so the word stays on the read port while
        // the output register is still occupied.
        if (out_free) begin
          out_d       = temper(mem_rdata_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      near_q      <= '0;
      far_q       <= '0;
      addr_q      <= '0;
      fill_q      <= '0;
      pl_q        <= '0;
      ph_q        <= '0;
      top_q       <= 1'b0;
      low_q       <= '0;
      w0_lsb_q    <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      near_q      <= near_d;
      far_q       <= far_d;
      addr_q      <= addr_d;
      fill_q      <= fill_d;
      pl_q        <= pl_d;
      ph_q        <= ph_d;
      top_q       <= top_d;
      low_q       <= low_d;
      w0_lsb_q    <= w0_lsb_d;
      out_q       <= out_d;
    end
  end

  // Single-port state table with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_addr];
  end

endmodule

`default_nettype wire

// ===== sv/twisted_gfsr64_random_generator.sv =====
// A plain read is taken in idle, read from the table and tempered into the
// output register; the back end takes no new item before it is through with
// the last one. The first request after reset also fills the table; once all
// 312 words are read, the next request first twists the table, with four
// single-port table accesses per word.
// Reset (asynchronous, active low) clears the seed and marks the table unseeded.
`timescale 1ns / 1ps
`default_nettype none

module twisted_gfsr64_random_generator #(
  parameter int unsigned QueueDepth = gfsr_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Seed register write port.
  input  wire logic        seed_we_i,
  input  wire logic [63:0] seed_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        request_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      random_value_o
);
  import gfsr_pkg::*;

  // The seed is only sampled by the back end when it fills the table, so a
  // write after seeding is held but has no effect; reset clears it.
  logic [63:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  logic       q_full, q_push, q_valid, q_pop;
  cmd_t       push_cmd, head_cmd;
  bk_status_t bk_status;

  // The front end keeps its own copy of the read index, so each queued
  // command already says whether the table must be filled or twisted first.
  gfsr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .request_i  (request_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  gfsr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .cmd_o      (head_cmd)
  );

  logic bk_cmd_ready;

  assign q_pop = q_valid && bk_cmd_ready;

  // The back end holds a finished word in its output register and can take the
  // next command once idle; tempering waits until that register is free or drained.
  gfsr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_i         (seed_q),
    .cmd_valid_i    (q_valid),
    .cmd_i          (head_cmd),
    .cmd_ready_o    (bk_cmd_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_value_o (random_value_o),
    .status_o       (bk_status)
  );

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // A fill or twist command starts a table sequence in the next cycle.
  a_table_op_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && (head_cmd.op == OP_FILL || head_cmd.op == OP_TWIST))
    |=> bk_status.table_busy)
    else $error("table sequence did not start");

  // No new result appears straight out of a fill or twist.
  a_no_result_in_table_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.table_busy |=> !$rose(out_valid_o))
    else $error("result raised during table sequence");

  // The back end only takes a command when it is idle.
  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> bk_status.idle)
    else $error("command taken while back end busy");

endmodule

`default_nettype wire
